[rtl/urx_pkg.sv]
// Shared types and constants of the radar UART frame receiver.
package urx_pkg;

    localparam int MAX_PAYLOAD  = 30;
    localparam int HEADER_BYTES = 8;

    localparam int CNT_W   = $clog2(HEADER_BYTES + MAX_PAYLOAD + 1);
    localparam int IDX_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FILTER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 1'd1;

    localparam logic [15:0] ACCEPT_ALL       = 16'hFFFF;
    localparam logic [15:0] TYPE_FILTER_RST  = 16'hFFFF;
    localparam logic [7:0]  START_BYTE_RST   = 8'h01;
    localparam logic [7:0]  CHECK_GOOD       = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_TYPE_BAD = 3'd2,
        ST_HDR_BAD  = 3'd3,
        ST_DATA_BAD = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0]      id;
        logic [15:0]      ftype;
        status_t          status;
        logic [LEN_W-1:0] len;
    } urx_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STAT,
        BK_READ,
        BK_WAIT
    } back_state_t;

endpackage

[rtl/radar_uart_frame_receiver.sv]
// A status item reaches out_valid through the queue entry, the back-end command register and the output register.
// A good frame's first payload beat passes the queue entry, the command register, the registered
// read of the payload store and the output register; a byte is read once the previous one is loaded.
// Input takes one beat per cycle; it stalls only at a payload byte while the previous payload
// is still being read out, or at a frame end while the two-entry command queue is full.
// Reset: hunting, queue and output empty, type_filter 0xFFFF, start_byte 0x01; store not cleared.
module radar_uart_frame_receiver import urx_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [15:0]           frame_id,
    output logic [15:0]           frame_type,
    output logic [7:0]            payload_byte,
    output logic                  byte_valid,
    output logic [2:0]            status,
    output logic                  last,
    output logic                  out_valid,
    input  logic                  out_stall
);

    // Payload store write side (front) and read side (back)
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    // Command queue between the two halves
    logic     push;
    urx_cmd_t push_cmd;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    urx_cmd_t q_cmd;

    // Release of the payload store once its last byte has been read out
    logic store_done;

    // Front: byte parsing, header checks, payload capture
    urx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full),
        .store_done (store_done)
    );

    // Payload bytes of one frame at a time
    urx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Hold finished-frame commands so the back end can stall on its own
    urx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (q_cmd)
    );

    // Back: emit beats from the output register
    urx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .store_done   (store_done),
        .frame_id     (frame_id),
        .frame_type   (frame_type),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .status       (status),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

[rtl/urx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module urx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/urx_front.sv]
// Front end: hunts for the start byte, parses the header, stores payload, pushes frame commands.
module urx_front import urx_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [7:0]            wr_data,
    output logic                  push,
    output urx_cmd_t              push_cmd,
    input  logic                  q_full,
    input  logic                  store_done
);

    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      type_reg, type_next;
    logic [7:0]       hxor_reg, hxor_next;
    logic [7:0]       dxor_reg, dxor_next;
    logic             lock_reg, lock_next;
    logic [15:0]      type_filter_reg;
    logic [7:0]       start_byte_reg;

    logic             accept;
    logic             hdr_pos;
    logic             too_long;
    logic             payload_pos;
    logic             end_pos;
    logic [CNT_W-1:0] pos_off;
    status_t          status;

    always_comb
    begin
        hdr_pos     = count_reg < CNT_W'(HEADER_BYTES);
        too_long    = (count_reg == CNT_W'(HEADER_BYTES - 1)) && (len_reg > 16'(MAX_PAYLOAD));
        payload_pos = !hdr_pos &&
                      (17'(count_reg) < (17'(HEADER_BYTES) + 17'(len_reg)));
        end_pos     = too_long || (!hdr_pos && !payload_pos);
        pos_off     = count_reg - CNT_W'(HEADER_BYTES);

        // Hold input while the queue is full at a frame end, or while the
        // back end still reads the payload of the previous frame.
        in_stall = in_frame_reg && ((end_pos && q_full) || (payload_pos && lock_reg));
        accept   = in_valid && !in_stall;

        if ((type_filter_reg != ACCEPT_ALL) && (type_filter_reg != type_reg))
            status = ST_TYPE_BAD;
        else if (hxor_reg != CHECK_GOOD)
            status = ST_HDR_BAD;
        else if ((dxor_reg ^ rx_byte) != CHECK_GOOD)
            status = ST_DATA_BAD;
        else
            status = ST_OK;

        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        hxor_next     = hxor_reg;
        dxor_next     = dxor_reg;
        lock_next     = lock_reg && !store_done;

        wr_en   = 1'b0;
        wr_addr = pos_off[IDX_W-1:0];
        wr_data = rx_byte;

        push           = 1'b0;
        push_cmd.id    = id_reg;
        push_cmd.ftype = type_reg;
        push_cmd.status = status;
        push_cmd.len   = len_reg[LEN_W-1:0];

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == start_byte_reg)
                begin
                    in_frame_next = 1'b1;
                    count_next    = CNT_W'(1);
                    hxor_next     = rx_byte;
                    dxor_next     = 8'h00;
                    id_next       = 16'h0000;
                    len_next      = 16'h0000;
                    type_next     = 16'h0000;
                end
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                if (hdr_pos)
                begin
                    hxor_next = hxor_reg ^ rx_byte;
                    case (count_reg)
                        CNT_W'(1): id_next   = {rx_byte, id_reg[7:0]};
                        CNT_W'(2): id_next   = {id_reg[15:8], rx_byte};
                        CNT_W'(3): len_next  = {rx_byte, len_reg[7:0]};
                        CNT_W'(4): len_next  = {len_reg[15:8], rx_byte};
                        CNT_W'(5): type_next = {rx_byte, type_reg[7:0]};
                        CNT_W'(6): type_next = {type_reg[15:8], rx_byte};
                        default: ;
                    endcase
                    if (too_long)
                    begin
                        push            = 1'b1;
                        push_cmd.status = ST_TOO_LONG;
                        in_frame_next   = 1'b0;
                        count_next      = '0;
                    end
                end
                else
                begin
                    dxor_next = dxor_reg ^ rx_byte;
                    if (payload_pos)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        push          = 1'b1;
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        if ((status == ST_OK) && (len_reg != 16'h0000))
                            lock_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            count_reg       <= '0;
            id_reg          <= '0;
            len_reg         <= '0;
            type_reg        <= '0;
            hxor_reg        <= '0;
            dxor_reg        <= '0;
            lock_reg        <= 1'b0;
            type_filter_reg <= TYPE_FILTER_RST;
            start_byte_reg  <= START_BYTE_RST;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            type_reg     <= type_next;
            hxor_reg     <= hxor_next;
            dxor_reg     <= dxor_next;
            lock_reg     <= lock_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TYPE_FILTER: type_filter_reg <= cfg_data;
                    CFG_START_BYTE:  start_byte_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[rtl/urx_queue.sv]
// Short command queue between the front end and the back end.
module urx_queue import urx_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  urx_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output urx_cmd_t pop_cmd
);

    urx_cmd_t          entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign full      = cnt_reg == QCNT_W'(Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_cmd   = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
            if (do_pop)
                rptr_reg <= (rptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

[rtl/urx_back.sv]
// Back end: takes frame commands and emits status items or stored payload bytes.
module urx_back import urx_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  urx_cmd_t         q_cmd,
    output logic             q_pop,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  logic [7:0]       rd_data,
    output logic             store_done,
    output logic [15:0]      frame_id,
    output logic [15:0]      frame_type,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic [2:0]       status,
    output logic             last,
    output logic             out_valid,
    input  logic             out_stall
);

    back_state_t      state_reg, state_next;
    urx_cmd_t         cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      id_reg, type_reg;
    logic [7:0]       byte_reg;
    logic             bvalid_reg, last_reg;
    logic [2:0]       status_reg;

    logic             out_free;
    logic             load;
    logic             load_byte;
    logic             final_byte;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        final_byte = (LEN_W'(idx_reg) + LEN_W'(1)) == cmd_reg.len;
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        store_done = 1'b0;
        load       = 1'b0;
        load_byte  = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    idx_next = '0;
                    if ((q_cmd.status != ST_OK) || (q_cmd.len == '0))
                        state_next = BK_STAT;
                    else
                        state_next = BK_READ;
                end
            end
            BK_STAT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_READ:
            begin
                rd_en      = 1'b1;
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_byte = 1'b1;
                    if (final_byte)
                    begin
                        store_done = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_free ? load : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            id_reg     <= cmd_reg.id;
            type_reg   <= cmd_reg.ftype;
            byte_reg   <= load_byte ? rd_data : 8'h00;
            bvalid_reg <= load_byte;
            status_reg <= load_byte ? ST_OK : cmd_reg.status;
            last_reg   <= load_byte ? final_byte : 1'b1;
        end
    end

    assign frame_id     = id_reg;
    assign frame_type   = type_reg;
    assign payload_byte = byte_reg;
    assign byte_valid   = bvalid_reg;
    assign status       = status_reg;
    assign last         = last_reg;
    assign out_valid    = out_valid_reg;

endmodule

[rtl/urx_checker.sv]
// Port-level checks of the frame receiver and their bind to the top level.
module urx_checker import urx_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic [15:0] frame_id,
    input logic [15:0] frame_type,
    input logic [7:0]  payload_byte,
    input logic        byte_valid,
    input logic [2:0]  status,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(frame_id)
            && $stable(status) && $stable(last) && $stable(byte_valid))
        else $error("output beat changed while stalled");

    // A beat without a payload byte is marked last and carries a zero byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && (payload_byte == 8'h00))
        else $error("status beat not marked last or carries data");

    // Payload beats only belong to good frames
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == ST_OK)
        else $error("payload beat with bad status");

    // Status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_DATA_BAD)
        else $error("status code out of range");

endmodule

bind radar_uart_frame_receiver urx_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_id     (frame_id),
    .frame_type   (frame_type),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .status       (status),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
);
